### hw/rtl/mvls_pkg.sv
// ----------------------------------------------------------------------------
// mvls_pkg: shared types and constants
// Item format between classifier and sequencer, register map, parity helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mvls_pkg;

  localparam int MV_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUMMY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SQ = 2'd2;

  localparam logic [CFG_DAT_W-1:0] MIN_SQ_RESET = 32'd100;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef struct packed {
    logic signed [MV_W-1:0] mv_x;
    logic signed [MV_W-1:0] mv_y;
    logic                   accepted;
    logic                   found;
    logic                   extract;
  } mvls_item_t;

  typedef struct packed {
    logic signed [MV_W-1:0] v;
    logic                   nz;
  } mvls_emb_t;

  // true when |x| is strictly larger than |y|
  function automatic logic larger_x(logic signed [MV_W-1:0] x,
                                    logic signed [MV_W-1:0] y);
    logic [MV_W:0] ex;
    logic [MV_W:0] ey;
    logic [MV_W:0] mx;
    logic [MV_W:0] my;
    ex = {x[MV_W-1], x};
    ey = {y[MV_W-1], y};
    mx = ex[MV_W] ? (~ex + 1'b1) : ex;
    my = ey[MV_W] ? (~ey + 1'b1) : ey;
    return mx > my;
  endfunction

  // step toward zero so the parity (inverted when negative) carries bit_in
  function automatic mvls_emb_t embed_comp(logic signed [MV_W-1:0] v,
                                           logic bit_in, logic dummy);
    mvls_emb_t r;
    r.v = v;
    if (v != '0 && !dummy) begin
      if (!v[MV_W-1] && bit_in != v[0]) begin
        r.v = v - 16'sd1;
      end else if (v[MV_W-1] && bit_in == v[0]) begin
        r.v = v + 16'sd1;
      end
    end
    r.nz = (r.v != '0);
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mvls_fifo.sv
// ----------------------------------------------------------------------------
// mvls_fifo: short item queue
// Decouples the classifier from the output sequencer; push and pop may share
// a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mvls_fifo #(
  parameter int DEPTH = 2
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  mvls_pkg::mvls_item_t    push_item,
  output logic                    not_full,
  input  wire                     pop,
  output mvls_pkg::mvls_item_t    pop_item,
  output logic                    not_empty
);
  import mvls_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mvls_item_t         store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mvls_front.sv
// ----------------------------------------------------------------------------
// mvls_front: vector classifier
// Two-stage pipe: parity embedding, then squares and threshold checks; the
// finished item is pushed into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mvls_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire signed [15:0]        mv_x_in,
  input  wire signed [15:0]        mv_y_in,
  input  wire                      data_bit,
  input  wire                      have_data,
  input  wire                      mode,
  input  wire                      dummy_pass,
  input  wire [31:0]               min_magnitude_sq,
  output logic                     q_push,
  output mvls_pkg::mvls_item_t     q_item,
  input  wire                      q_not_full
);
  import mvls_pkg::*;

  // stage 1 combinational: first and second embedding pass
  logic                   sel0;
  logic signed [MV_W-1:0] c0;
  mvls_emb_t              e1;
  logic signed [MV_W-1:0] x1;
  logic signed [MV_W-1:0] y1;
  logic                   sel1;
  mvls_emb_t              e2;
  logic signed [MV_W-1:0] x2;
  logic signed [MV_W-1:0] y2;

  always_comb begin
    sel0 = larger_x(mv_x_in, mv_y_in);
    c0   = sel0 ? mv_x_in : mv_y_in;
    e1   = embed_comp(c0, data_bit, dummy_pass);
    x1   = sel0 ? e1.v : mv_x_in;
    y1   = sel0 ? mv_y_in : e1.v;
    sel1 = larger_x(x1, y1);
    e2   = embed_comp(sel1 ? x1 : y1, data_bit, dummy_pass);
    x2   = sel1 ? e2.v : x1;
    y2   = sel1 ? y1 : e2.v;
  end

  // stage 1 registers
  logic                   s1_valid;
  logic signed [MV_W-1:0] s1_x0;
  logic signed [MV_W-1:0] s1_y0;
  logic signed [MV_W-1:0] s1_xf;
  logic signed [MV_W-1:0] s1_yf;
  logic                   s1_have;
  logic                   s1_ok;
  logic                   s1_nz0;
  logic                   s1_found;
  logic                   s1_mode;

  // stage 2 registers
  logic                   s2_valid;
  logic signed [MV_W-1:0] s2_x0;
  logic signed [MV_W-1:0] s2_y0;
  logic signed [MV_W-1:0] s2_xf;
  logic signed [MV_W-1:0] s2_yf;
  logic [30:0]            s2_sqx0;
  logic [30:0]            s2_sqy0;
  logic [30:0]            s2_sqxf;
  logic [30:0]            s2_sqyf;
  logic                   s2_have;
  logic                   s2_ok;
  logic                   s2_nz0;
  logic                   s2_found;
  logic                   s2_mode;

  logic s1_ready;
  logic s2_ready;
  logic s1_load;
  logic s2_load;

  assign s2_ready = !s2_valid || q_not_full;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign s1_load  = in_valid && s1_ready;
  assign s2_load  = s1_valid && s2_ready;
  assign q_push   = s2_valid && q_not_full;

  // squares are at most 2^30, so the top product bit is always clear
  logic signed [31:0] p_x0;
  logic signed [31:0] p_y0;
  logic signed [31:0] p_xf;
  logic signed [31:0] p_yf;

  always_comb begin
    p_x0 = s1_x0 * s1_x0;
    p_y0 = s1_y0 * s1_y0;
    p_xf = s1_xf * s1_xf;
    p_yf = s1_yf * s1_yf;
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_x0    <= mv_x_in;
      s1_y0    <= mv_y_in;
      // second pass only runs when the first left a nonzero component
      s1_xf    <= e1.nz ? x2 : x1;
      s1_yf    <= e1.nz ? y2 : y1;
      s1_have  <= have_data;
      s1_ok    <= e1.nz && e2.nz;
      s1_nz0   <= (c0 != '0);
      s1_found <= c0[0] ^ c0[MV_W-1];
      s1_mode  <= mode;
    end
    if (s2_load) begin
      s2_x0    <= s1_x0;
      s2_y0    <= s1_y0;
      s2_xf    <= s1_xf;
      s2_yf    <= s1_yf;
      s2_sqx0  <= p_x0[30:0];
      s2_sqy0  <= p_y0[30:0];
      s2_sqxf  <= p_xf[30:0];
      s2_sqyf  <= p_yf[30:0];
      s2_have  <= s1_have;
      s2_ok    <= s1_ok;
      s2_nz0   <= s1_nz0;
      s2_found <= s1_found;
      s2_mode  <= s1_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // stage 2 combinational: threshold compares and classification
  logic [31:0] sum0;
  logic [31:0] sumf;
  logic        use0;
  logic        usef;
  logic        embed_on;

  always_comb begin
    sum0     = {1'b0, s2_sqx0} + {1'b0, s2_sqy0};
    sumf     = {1'b0, s2_sqxf} + {1'b0, s2_sqyf};
    use0     = (sum0 >= min_magnitude_sq);
    usef     = (sumf >= min_magnitude_sq);
    embed_on = s2_have && use0;
    q_item.extract = (s2_mode == MODE_EXTRACT);
    if (s2_mode == MODE_EXTRACT) begin
      q_item.mv_x     = s2_x0;
      q_item.mv_y     = s2_y0;
      q_item.accepted = use0 && s2_nz0;
      q_item.found    = use0 && s2_nz0 && s2_found;
    end else begin
      q_item.mv_x     = embed_on ? s2_xf : s2_x0;
      q_item.mv_y     = embed_on ? s2_yf : s2_y0;
      q_item.accepted = embed_on && s2_ok && usef;
      q_item.found    = 1'b0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mvls_back.sv
// ----------------------------------------------------------------------------
// mvls_back: bit sequencer and output register
// Packs extracted bits LSB first, counts accepted bits, holds the result
// until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mvls_back (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      q_not_empty,
  input  mvls_pkg::mvls_item_t     q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [15:0]       mv_x_out,
  output logic signed [15:0]       mv_y_out,
  output logic                     bit_accepted,
  output logic                     found_bit,
  output logic                     byte_ready,
  output logic [7:0]               recovered_byte,
  output logic [31:0]              bits_done
);
  import mvls_pkg::*;

  logic [7:0]  byte_accumulator;
  logic [2:0]  bit_position;
  logic [31:0] processed_count;

  logic [7:0]  acc_next;
  logic [7:0]  byte_accumulator_next;
  logic [2:0]  bit_position_next;
  logic [31:0] processed_count_next;
  logic        ready_next;
  logic [7:0]  byte_next;

  assign q_pop = q_not_empty && (!out_valid || out_ready);

  always_comb begin
    acc_next              = byte_accumulator |
                            (8'(q_item.found) << bit_position);
    byte_accumulator_next = byte_accumulator;
    bit_position_next     = bit_position;
    processed_count_next  = processed_count;
    ready_next            = 1'b0;
    byte_next             = '0;
    if (q_item.accepted) begin
      bit_position_next    = bit_position + 1'b1;
      processed_count_next = processed_count + 1'b1;
      if (q_item.extract) begin
        // eighth bit closes the byte
        if (bit_position == 3'd7) begin
          ready_next            = 1'b1;
          byte_next             = acc_next;
          byte_accumulator_next = '0;
        end else begin
          byte_accumulator_next = acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mv_x_out       <= q_item.mv_x;
      mv_y_out       <= q_item.mv_y;
      bit_accepted   <= q_item.accepted;
      found_bit      <= q_item.found;
      byte_ready     <= ready_next;
      recovered_byte <= byte_next;
      bits_done      <= processed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      byte_accumulator <= '0;
      bit_position     <= '0;
      processed_count  <= '0;
    end else begin
      if (q_pop) begin
        out_valid        <= 1'b1;
        byte_accumulator <= byte_accumulator_next;
        bit_position     <= bit_position_next;
        processed_count  <= processed_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/motion_vector_lsb_stego.sv
// ----------------------------------------------------------------------------
// motion_vector_lsb_stego: motion vector parity embed / extract
// Hides payload bits in, or recovers them from, motion vector pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one vector pair per transfer with
//   its payload bit; output channel (out_valid/out_ready) returns exactly one
//   result per input, in order. The config channel (cfg_valid/cfg_ready,
//   always ready) writes mode, dummy_pass and min_magnitude_sq; write it only
//   while no item is in flight.
//   Throughput: one item per cycle while the receiver takes results. A result
//   passes the first classifier stage (embedding), which loads on the input
//   transfer itself, then the second stage (16x16 squares feeding the
//   threshold compare), the queue and the output register.
//   When the receiver stalls, the result is held, the queue fills
//   (QUEUE_DEPTH entries) and then the classifier pipe backs up to in_ready.
//   Reset empties the pipe and queue, clears the byte accumulator, bit
//   position and bit count, and restores the registers (threshold 100).
// ----------------------------------------------------------------------------
`default_nettype none

module motion_vector_lsb_stego #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire signed [15:0]  mv_x_in,
  input  wire signed [15:0]  mv_y_in,
  input  wire                data_bit,
  input  wire                have_data,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [15:0] mv_x_out,
  output logic signed [15:0] mv_y_out,
  output logic               bit_accepted,
  output logic               found_bit,
  output logic               byte_ready,
  output logic [7:0]         recovered_byte,
  output logic [31:0]        bits_done,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [1:0]          cfg_index,
  input  wire [31:0]         cfg_data
);
  import mvls_pkg::*;

  logic        mode;
  logic        dummy_pass;
  logic [31:0] min_magnitude_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_EMBED;
      dummy_pass       <= 1'b0;
      min_magnitude_sq <= MIN_SQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:   mode             <= cfg_data[0];
        CFG_DUMMY:  dummy_pass       <= cfg_data[0];
        CFG_MIN_SQ: min_magnitude_sq <= cfg_data;
        default: begin
          // unmapped index: ignored
        end
      endcase
    end
  end

  mvls_item_t push_item;
  mvls_item_t pop_item;
  logic       push;
  logic       pop;
  logic       not_full;
  logic       not_empty;

  mvls_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mv_x_in          (mv_x_in),
    .mv_y_in          (mv_y_in),
    .data_bit         (data_bit),
    .have_data        (have_data),
    .mode             (mode),
    .dummy_pass       (dummy_pass),
    .min_magnitude_sq (min_magnitude_sq),
    .q_push           (push),
    .q_item           (push_item),
    .q_not_full       (not_full)
  );

  mvls_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .not_full  (not_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (not_empty)
  );

  mvls_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (not_empty),
    .q_item         (pop_item),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mv_x_out       (mv_x_out),
    .mv_y_out       (mv_y_out),
    .bit_accepted   (bit_accepted),
    .found_bit      (found_bit),
    .byte_ready     (byte_ready),
    .recovered_byte (recovered_byte),
    .bits_done      (bits_done)
  );

endmodule

`default_nettype wire

### hw/rtl/mvls_checker.sv
// ----------------------------------------------------------------------------
// mvls_checker: port-level assertions
// Watches the output channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mvls_checker (
  input wire               clk,
  input wire               rst,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [15:0] mv_x_out,
  input wire signed [15:0] mv_y_out,
  input wire               bit_accepted,
  input wire               found_bit,
  input wire               byte_ready,
  input wire [7:0]         recovered_byte,
  input wire [31:0]        bits_done
);

  // bit count seen on the last output transfer
  logic [31:0] last_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_done <= '0;
    end else if (out_valid && out_ready) begin
      last_done <= bits_done;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mv_x_out) &&
      $stable(mv_y_out) && $stable(bits_done) && $stable(bit_accepted))
    else $error("stalled result changed");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> bits_done == 32'(last_done + {31'b0, bit_accepted}))
    else $error("bit count does not follow accepted bits");

  a_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_ready |-> bit_accepted)
    else $error("byte completed without an accepted bit");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bit_accepted |-> !found_bit && !byte_ready && recovered_byte == 8'd0)
    else $error("rejected vector carries bit data");

endmodule

bind motion_vector_lsb_stego mvls_checker u_mvls_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .mv_x_out       (mv_x_out),
  .mv_y_out       (mv_y_out),
  .bit_accepted   (bit_accepted),
  .found_bit      (found_bit),
  .byte_ready     (byte_ready),
  .recovered_byte (recovered_byte),
  .bits_done      (bits_done)
);

`default_nettype wire

### tb/stego_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stego_checker: result predictor and comparator
// Watches the config, input and output channels of the motion vector stego
// block, predicts each result from its own copy of registers and bit state,
// and compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module stego_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire signed [15:0] mv_x_in,
  input  wire signed [15:0] mv_y_in,
  input  wire               data_bit,
  input  wire               have_data,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire signed [15:0] mv_x_out,
  input  wire signed [15:0] mv_y_out,
  input  wire               bit_accepted,
  input  wire               found_bit,
  input  wire               byte_ready,
  input  wire [7:0]         recovered_byte,
  input  wire [31:0]        bits_done,
  input  wire               cfg_valid,
  input  wire               cfg_ready,
  input  wire [1:0]         cfg_index,
  input  wire [31:0]        cfg_data,
  output int                errors,
  output int                outstanding
);

  import mvls_pkg::*;

  typedef struct packed {
    logic signed [15:0] mv_x;
    logic signed [15:0] mv_y;
    logic               accepted;
    logic               found;
    logic               byte_done;
    logic [7:0]         byte_val;
    logic [31:0]        count;
  } stego_result_t;

  logic        mode_r;
  logic        dummy_r;
  logic [31:0] min_sq_r;
  logic [7:0]  gathered_bits;
  logic [2:0]  bit_slot;
  logic [31:0] accepted_total;

  stego_result_t due_outputs[$];

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic is_usable(int x, int y);
    longint sq;
    sq = longint'(x) * longint'(x) + longint'(y) * longint'(y);
    return sq >= longint'(min_sq_r);
  endfunction

  // step toward zero so that parity (inverted when negative) carries b
  function automatic logic nudge(inout int v, input logic b);
    logic lsb;
    if (v == 0) return 1'b0;
    lsb = v[0];
    if (!dummy_r) begin
      if (v > 0 && b != lsb) v = v - 1;
      else if (v < 0 && b == lsb) v = v + 1;
    end
    return v != 0;
  endfunction

  function automatic logic nudge_larger(inout int x, inout int y, input logic b);
    if (mag(x) > mag(y)) return nudge(x, b);
    return nudge(y, b);
  endfunction

  function automatic stego_result_t predict_stego(logic signed [15:0] xi,
                                                  logic signed [15:0] yi,
                                                  logic b, logic h);
    stego_result_t r;
    int   x;
    int   y;
    int   v;
    logic ok;
    logic f;
    x  = int'(xi);
    y  = int'(yi);
    ok = 1'b0;
    f  = 1'b0;
    r  = '0;
    if (mode_r == MODE_EMBED) begin
      if (h && is_usable(x, y)) begin
        // second pass may pick the other component after the first nudge
        if (nudge_larger(x, y, b)) begin
          ok = nudge_larger(x, y, b);
          ok = ok && is_usable(x, y);
        end
      end
      if (ok) begin
        bit_slot       = bit_slot + 3'd1;
        accepted_total = accepted_total + 32'd1;
      end
    end else begin
      if (is_usable(x, y)) begin
        v = (mag(x) > mag(y)) ? x : y;
        if (v != 0) begin
          ok = 1'b1;
          f  = v[0] ^ (v < 0);
        end
      end
      if (ok) begin
        gathered_bits[bit_slot] = gathered_bits[bit_slot] | f;
        bit_slot       = bit_slot + 3'd1;
        accepted_total = accepted_total + 32'd1;
        if (bit_slot == 3'd0) begin
          r.byte_done   = 1'b1;
          r.byte_val    = gathered_bits;
          gathered_bits = '0;
        end
      end
    end
    r.mv_x     = x[15:0];
    r.mv_y     = y[15:0];
    r.accepted = ok;
    r.found    = f;
    r.count    = accepted_total;
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    stego_result_t want;
    if (rst) begin
      mode_r         = MODE_EMBED;
      dummy_r        = 1'b0;
      min_sq_r       = MIN_SQ_RESET;
      gathered_bits  = '0;
      bit_slot       = '0;
      accepted_total = '0;
      due_outputs.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:   mode_r   = cfg_data[0];
          CFG_DUMMY:  dummy_r  = cfg_data[0];
          CFG_MIN_SQ: min_sq_r = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_outputs.size() == 0) begin
          $error("output transfer with no expected result");
          errors++;
        end else begin
          want = due_outputs.pop_front();
          check_field("mv_x_out", longint'(want.mv_x), longint'(mv_x_out));
          check_field("mv_y_out", longint'(want.mv_y), longint'(mv_y_out));
          check_field("bit_accepted", longint'(want.accepted), longint'(bit_accepted));
          check_field("found_bit", longint'(want.found), longint'(found_bit));
          check_field("byte_ready", longint'(want.byte_done), longint'(byte_ready));
          check_field("recovered_byte", longint'(want.byte_val),
                      longint'(recovered_byte));
          check_field("bits_done", longint'(want.count), longint'(bits_done));
        end
      end
      if (in_valid && in_ready)
        due_outputs.push_back(predict_stego(mv_x_in, mv_y_in, data_bit, have_data));
      outstanding <= due_outputs.size();
    end
  end

endmodule

### tb/motion_vector_lsb_stego_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_vector_lsb_stego_tb: top-level testbench
// Directed embed/extract corner cases, then randomised phases with random
// register settings and random idling on both channels; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------

module motion_vector_lsb_stego_tb;

  import mvls_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 75;

  logic               clk;
  logic               rst;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] mv_x_in = '0;
  logic signed [15:0] mv_y_in = '0;
  logic               data_bit = 1'b0;
  logic               have_data = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] mv_x_out;
  logic signed [15:0] mv_y_out;
  logic               bit_accepted;
  logic               found_bit;
  logic               byte_ready;
  logic [7:0]         recovered_byte;
  logic [31:0]        bits_done;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  int   errors;
  int   outstanding;
  int   idle_cycles;
  int   ready_run;
  logic calm;

  motion_vector_lsb_stego i_dut (
    .clk, .rst,
    .in_valid, .in_ready, .mv_x_in, .mv_y_in, .data_bit, .have_data,
    .out_valid, .out_ready, .mv_x_out, .mv_y_out, .bit_accepted, .found_bit,
    .byte_ready, .recovered_byte, .bits_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  stego_checker i_checker (
    .clk, .rst,
    .in_valid, .in_ready, .mv_x_in, .mv_y_in, .data_bit, .have_data,
    .out_valid, .out_ready, .mv_x_out, .mv_y_out, .bit_accepted, .found_bit,
    .byte_ready, .recovered_byte, .bits_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones; none while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_run <= 0;
    end else if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (calm || !out_ready) begin
      out_ready <= 1'b1;
      ready_run <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b0;
      ready_run <= pick_gap();
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_vector(int x, int y, logic b, logic h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mv_x_in   <= x[15:0];
    mv_y_in   <= y[15:0];
    data_bit  <= b;
    have_data <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(logic md, logic dummy, logic [31:0] min_sq);
    write_reg(CFG_MODE, {31'd0, md});
    write_reg(CFG_DUMMY, {31'd0, dummy});
    write_reg(CFG_MIN_SQ, min_sq);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender off until every result has been transferred
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int rand_component();
    int r;
    int pick;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 64) - 32;
    if (r < 75) return $urandom_range(0, 2048) - 1024;
    if (r < 90) return $urandom_range(0, 65535) - 32768;
    pick = $urandom_range(0, 5);
    case (pick)
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic logic [31:0] rand_threshold();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32'd0;
      1:       return MIN_SQ_RESET;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(0, 32'h8000_0000);
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  initial begin
    calm = 1'b0;
    rst  = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // embed, threshold at reset value
    set_config(MODE_EMBED, 1'b0, MIN_SQ_RESET);
    push_vector(0, 0, 1'b1, 1'b1);
    push_vector(10, 0, 1'b0, 1'b1);
    push_vector(10, 0, 1'b1, 1'b1);   // nudge drops below threshold: rejected, nudged vector output
    push_vector(-12, 3, 1'b0, 1'b1);
    push_vector(-12, 3, 1'b1, 1'b1);
    push_vector(7, -7, 1'b1, 1'b1);   // tie goes to y
    push_vector(32767, -32768, 1'b1, 1'b1);
    push_vector(-32768, 32767, 1'b0, 1'b1);
    push_vector(20, 20, 1'b1, 1'b0);  // no payload
    wait_drain();

    // threshold zero: zero chosen component still rejects
    set_config(MODE_EMBED, 1'b0, 32'd0);
    push_vector(0, 0, 1'b1, 1'b1);
    push_vector(1, 0, 1'b0, 1'b1);
    push_vector(0, -1, 1'b0, 1'b1);
    wait_drain();

    set_config(MODE_EMBED, 1'b1, MIN_SQ_RESET);
    push_vector(11, 2, 1'b0, 1'b1);
    push_vector(-9, -9, 1'b1, 1'b1);
    wait_drain();

    // extract: enough accepted bits to complete a byte
    set_config(MODE_EXTRACT, 1'b0, 32'd0);
    push_vector(0, 0, 1'b0, 1'b0);
    push_vector(1, 0, 1'b0, 1'b0);
    push_vector(-1, 0, 1'b0, 1'b0);
    push_vector(32767, -32768, 1'b0, 1'b0);
    push_vector(-32768, 32767, 1'b0, 1'b0);
    push_vector(3, -5, 1'b0, 1'b0);
    push_vector(8, 2, 1'b0, 1'b0);
    push_vector(-6, 1, 1'b0, 1'b0);
    push_vector(4, 4, 1'b0, 1'b0);
    wait_drain();

    set_config(MODE_EXTRACT, 1'b0, 32'h8000_0000);
    push_vector(-32768, -32768, 1'b1, 1'b1);
    push_vector(32767, 32767, 1'b1, 1'b1);
    wait_drain();

    for (int p = 0; p < PHASES; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      set_config(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
                 rand_threshold());
      for (int n = 0; n < PHASE_LEN; n++)
        push_vector(rand_component(), rand_component(), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 9) != 0));
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
